/* rtl/core/mhem_pkg.sv */
// ----------------------------------------------------------------------------
// mhem_pkg - motor hour and energy meter shared definitions
// Payload types, configuration layout, register indexes and defaults.
// ----------------------------------------------------------------------------
`default_nettype none

package mhem_pkg;

	// accumulator width default, legal range 40..64
	localparam int ACC_WIDTH_DEF = 48;

	localparam int CFG_DATA_W  = 32;
	localparam int CFG_INDEX_W = 3;
	localparam int PROD_W      = 33;

	// request commands
	localparam logic CMD_SAMPLE  = 1'b0;
	localparam logic CMD_RESTORE = 1'b1;

	// configuration register indexes
	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_SAMPLE_INTERVAL   = 3'd0,
		REG_PERIODS_PER_BLOCK = 3'd1,
		REG_BLOCKS_PER_HOUR   = 3'd2,
		REG_ENERGY_SAVE_MASK  = 3'd3,
		REG_PRESET_HOURS      = 3'd4,
		REG_PRESET_BLOCKS     = 3'd5,
		REG_PRESET_ENERGY     = 3'd6
	} mhem_reg_t;

	// reset values of the configuration registers
	localparam logic [15:0] SAMPLE_INTERVAL_RST   = 16'd10;
	localparam logic [15:0] PERIODS_PER_BLOCK_RST = 16'd6000;
	localparam logic [7:0]  BLOCKS_PER_HOUR_RST   = 8'd5;
	localparam logic [15:0] ENERGY_SAVE_MASK_RST  = 16'h3fff;

	// input request payload
	typedef struct packed {
		logic               cmd;
		logic [31:0]        now_time;
		logic signed [15:0] current;
		logic [15:0]        voltage;
	} mhem_in_t;

	// result payload
	typedef struct packed {
		logic [15:0] run_hours;
		logic [15:0] block_count;
		logic [31:0] energy_report;
		logic        save_energy;
		logic        save_hours;
		logic        save_blocks;
	} mhem_out_t;

	// request with its current x voltage product
	typedef struct packed {
		logic                     cmd;
		logic [31:0]              now_time;
		logic signed [PROD_W-1:0] product;
	} mhem_req_t;

	// configuration register set
	typedef struct packed {
		logic [15:0] sample_interval;
		logic [15:0] periods_per_block;
		logic [7:0]  blocks_per_hour;
		logic [15:0] energy_save_mask;
		logic [15:0] preset_hours;
		logic [15:0] preset_blocks;
		logic [31:0] preset_energy;
	} mhem_cfg_t;

endpackage

`default_nettype wire

/* rtl/core/mhem_update.sv */
// ----------------------------------------------------------------------------
// mhem_update - meter state and combinational update
// Holds time mark, energy accumulator and counters; computes the result of
// one request from the current state and commits the new state on fire.
// ----------------------------------------------------------------------------
`default_nettype none

module mhem_update #(
	parameter int ACC_WIDTH = mhem_pkg::ACC_WIDTH_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                fire,
	input  wire mhem_pkg::mhem_req_t req,
	input  wire mhem_pkg::mhem_cfg_t cfg,
	output      mhem_pkg::mhem_out_t res
);

	localparam logic [ACC_WIDTH-1:0] ACC_MAX = {1'b0, {(ACC_WIDTH-1){1'b1}}};
	localparam logic [ACC_WIDTH-1:0] ACC_MIN = {1'b1, {(ACC_WIDTH-1){1'b0}}};
	localparam int                   EXT_W   = ACC_WIDTH + 1 - mhem_pkg::PROD_W;

	logic [31:0]          time_mark_q;
	logic [ACC_WIDTH-1:0] energy_acc_q;
	logic [15:0]          period_count_q;
	logic [15:0]          block_counter_q;
	logic [15:0]          hour_counter_q;

	logic [31:0]          mark_n;
	logic [ACC_WIDTH-1:0] acc_n;
	logic [15:0]          period_n;
	logic [15:0]          block_n;
	logic [15:0]          hour_n;

	logic [31:0]          elapsed;
	logic                 take;
	logic [ACC_WIDTH:0]   sum;
	logic [ACC_WIDTH-1:0] acc_sat;
	logic [63:0]          preset_scaled;
	logic [ACC_WIDTH-1:0] acc_preset;
	logic [15:0]          period_inc;
	logic [15:0]          block_inc;
	logic [63:0]          energy_mag;
	logic [31:0]          energy_report;
	logic                 save_energy;
	logic                 save_hours;
	logic                 save_blocks;

	// saturating accumulate of the sample product
	always_comb begin
		sum = {energy_acc_q[ACC_WIDTH-1], energy_acc_q}
			+ {{EXT_W{req.product[mhem_pkg::PROD_W-1]}}, req.product};
		if (sum[ACC_WIDTH] != sum[ACC_WIDTH-1]) begin
			acc_sat = sum[ACC_WIDTH] ? ACC_MIN : ACC_MAX;
		end else begin
			acc_sat = sum[ACC_WIDTH-1:0];
		end
	end

	// preset energy scaled to accumulator units, clamped to the positive max
	always_comb begin
		preset_scaled = 64'(cfg.preset_energy) << 8;
		if (preset_scaled > 64'(ACC_MAX)) begin
			acc_preset = ACC_MAX;
		end else begin
			acc_preset = preset_scaled[ACC_WIDTH-1:0];
		end
	end

	assign elapsed    = req.now_time - time_mark_q;
	assign take       = elapsed > 32'(cfg.sample_interval);
	assign period_inc = take ? period_count_q + 16'd1 : period_count_q;
	assign block_inc  = block_counter_q + 16'd1;

	// next state and save strobes
	always_comb begin
		mark_n      = time_mark_q;
		acc_n       = energy_acc_q;
		period_n    = period_count_q;
		block_n     = block_counter_q;
		hour_n      = hour_counter_q;
		save_energy = 1'b0;
		save_hours  = 1'b0;
		save_blocks = 1'b0;
		if (req.cmd == mhem_pkg::CMD_RESTORE) begin
			hour_n   = cfg.preset_hours;
			block_n  = cfg.preset_blocks;
			acc_n    = acc_preset;
			period_n = '0;
			mark_n   = req.now_time;
		end else begin
			if (take) begin
				acc_n  = acc_sat;
				mark_n = req.now_time;
			end
			period_n    = period_inc;
			save_energy = (period_inc & cfg.energy_save_mask) == 16'd0;
			if (period_inc > cfg.periods_per_block) begin
				period_n    = '0;
				block_n     = block_inc;
				save_blocks = 1'b1;
				if (block_inc > 16'(cfg.blocks_per_hour)) begin
					hour_n     = hour_counter_q + 16'd1;
					block_n    = '0;
					save_hours = 1'b1;
				end
			end
		end
	end

	// report: shift out the fraction, negative reads zero, clamp at the top
	always_comb begin
		energy_mag = 64'(acc_n[ACC_WIDTH-2:0]) >> 8;
		if (acc_n[ACC_WIDTH-1]) begin
			energy_report = '0;
		end else if (|energy_mag[63:32]) begin
			energy_report = '1;
		end else begin
			energy_report = energy_mag[31:0];
		end
	end

	assign res = '{run_hours: hour_n, block_count: block_n, energy_report: energy_report,
		save_energy: save_energy, save_hours: save_hours, save_blocks: save_blocks};

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_mark_q     <= '0;
			energy_acc_q    <= '0;
			period_count_q  <= '0;
			block_counter_q <= '0;
			hour_counter_q  <= '0;
		end else if (fire) begin
			time_mark_q     <= mark_n;
			energy_acc_q    <= acc_n;
			period_count_q  <= period_n;
			block_counter_q <= block_n;
			hour_counter_q  <= hour_n;
		end
	end

endmodule

`default_nettype wire

/* rtl/core/motor_hour_and_energy_meter.sv */
// ----------------------------------------------------------------------------
// motor_hour_and_energy_meter - run hour and output energy meter
// Input register, then current x voltage product and state update in one
// pass into the result register.
// ----------------------------------------------------------------------------
// The block takes one request per clock unless the result side stalls it
// and returns one result per request, in order; a request is registered in
// the input register and then in the result register, which holds while the
// result side is stalled. A sample request (cmd 0) counts a period and adds
// current times voltage to the energy accumulator when more than
// sample_interval time counts have passed since the last mark; periods roll
// into blocks and blocks into run hours. A restore request (cmd 1) loads the
// presets, clears the period count and sets the time mark. The product, the
// accumulate and the counter updates run between the input register and the
// result register, and the state written by one request is seen by the next,
// so back-to-back requests need no gap. A stalled result holds the input
// register, and sample_ready then follows result_ready in the same cycle.
// Configuration registers are written through cfg_we/cfg_index/cfg_wdata and
// should only change while no request is in flight.
`default_nettype none

module motor_hour_and_energy_meter #(
	parameter int ACC_WIDTH = mhem_pkg::ACC_WIDTH_DEF
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                sample_valid,
	output      logic                                sample_ready,
	input  wire mhem_pkg::mhem_in_t                  sample,
	output      logic                                result_valid,
	input  wire logic                                result_ready,
	output      mhem_pkg::mhem_out_t                 result,
	input  wire logic                                cfg_we,
	input  wire logic [mhem_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  wire logic [mhem_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

	mhem_pkg::mhem_cfg_t cfg_q;
	mhem_pkg::mhem_in_t  req_s1;
	mhem_pkg::mhem_req_t req_mul;
	mhem_pkg::mhem_out_t res_next;
	logic                vld_s1;
	logic                out_vld_q;
	logic                mv2;
	logic                accept;

	// stage flow: the input register moves when the result register is free
	assign mv2          = vld_s1 && (!out_vld_q || result_ready);
	assign sample_ready = !vld_s1 || mv2;
	assign accept       = sample_valid && sample_ready;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sample_interval   <= mhem_pkg::SAMPLE_INTERVAL_RST;
			cfg_q.periods_per_block <= mhem_pkg::PERIODS_PER_BLOCK_RST;
			cfg_q.blocks_per_hour   <= mhem_pkg::BLOCKS_PER_HOUR_RST;
			cfg_q.energy_save_mask  <= mhem_pkg::ENERGY_SAVE_MASK_RST;
			cfg_q.preset_hours      <= '0;
			cfg_q.preset_blocks     <= '0;
			cfg_q.preset_energy     <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				mhem_pkg::REG_SAMPLE_INTERVAL:   cfg_q.sample_interval   <= cfg_wdata[15:0];
				mhem_pkg::REG_PERIODS_PER_BLOCK: cfg_q.periods_per_block <= cfg_wdata[15:0];
				mhem_pkg::REG_BLOCKS_PER_HOUR:   cfg_q.blocks_per_hour   <= cfg_wdata[7:0];
				mhem_pkg::REG_ENERGY_SAVE_MASK:  cfg_q.energy_save_mask  <= cfg_wdata[15:0];
				mhem_pkg::REG_PRESET_HOURS:      cfg_q.preset_hours      <= cfg_wdata[15:0];
				mhem_pkg::REG_PRESET_BLOCKS:     cfg_q.preset_blocks     <= cfg_wdata[15:0];
				mhem_pkg::REG_PRESET_ENERGY:     cfg_q.preset_energy     <= cfg_wdata[31:0];
				default: ;
			endcase
		end
	end

	// valid bits of the pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (sample_ready) begin
				vld_s1 <= sample_valid;
			end
			if (!out_vld_q || result_ready) begin
				out_vld_q <= vld_s1;
			end
		end
	end

	// input register
	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1 <= sample;
		end
	end

	// signed current times unsigned voltage
	always_comb begin
		req_mul.cmd      = req_s1.cmd;
		req_mul.now_time = req_s1.now_time;
		req_mul.product  = $signed({{17{req_s1.current[15]}}, req_s1.current})
			* $signed({17'd0, req_s1.voltage});
	end

	mhem_update #(
		.ACC_WIDTH(ACC_WIDTH)
	) u_update (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (mv2),
		.req    (req_mul),
		.cfg    (cfg_q),
		.res    (res_next)
	);

	// result register
	always_ff @(posedge clk) begin
		if (mv2) begin
			result <= res_next;
		end
	end

	assign result_valid = out_vld_q;

endmodule

`default_nettype wire

/* rtl/core/mhem_checker.sv */
// ----------------------------------------------------------------------------
// mhem_port_checker - port-level checks for the meter
// Watches the top-level ports; bound to motor_hour_and_energy_meter.
// ----------------------------------------------------------------------------
`default_nettype none

module mhem_port_checker (
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                sample_ready,
	input wire logic                result_valid,
	input wire logic                result_ready,
	input wire mhem_pkg::mhem_out_t result
);

	// an hour is only counted at the end of a block
	a_hour_needs_block: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.save_hours |-> result.save_blocks)
		else $error("hour counted without block end");

	// counting an hour restarts the block count
	a_hour_clears_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.save_hours |-> result.block_count == 16'd0)
		else $error("block count not cleared on hour");

	// with no result waiting the pipeline can always take a request
	a_ready_when_drained: assert property (@(posedge clk) disable iff (!arst_n)
		!result_valid |-> sample_ready)
		else $error("request refused with empty output");

	// a stalled result holds
	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result))
		else $error("stalled result changed");

endmodule

bind motor_hour_and_energy_meter mhem_port_checker u_mhem_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.sample_ready (sample_ready),
	.result_valid (result_valid),
	.result_ready (result_ready),
	.result       (result)
);

`default_nettype wire
